FILE: design/dual_interval_timer_with_interrupts_assert.svh
// Assertion macros shared by the timer block.
// Both macros sample on clk; DIT_ASSERT expects an active-low reset named rst_n.
`ifndef DUAL_INTERVAL_TIMER_WITH_INTERRUPTS_ASSERT_SVH
`define DUAL_INTERVAL_TIMER_WITH_INTERRUPTS_ASSERT_SVH

`ifndef ASSERT_OFF

// Property checked outside of reset
`define DIT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dit assertion failed");

// Property checked on every edge, reset included
`define DIT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dit assertion failed");

`else

`define DIT_ASSERT(lbl, prop)
`define DIT_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: design/dit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dit_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Register map
  localparam logic [3:0] ADDR_TA_LO = 4'h4;
  localparam logic [3:0] ADDR_TA_HI = 4'h5;
  localparam logic [3:0] ADDR_TB_LO = 4'h6;
  localparam logic [3:0] ADDR_TB_HI = 4'h7;
  localparam logic [3:0] ADDR_ICR   = 4'hd;
  localparam logic [3:0] ADDR_CRA   = 4'he;
  localparam logic [3:0] ADDR_CRB   = 4'hf;

  // Control register fields
  localparam int unsigned CTL_START_BIT   = 0;
  localparam int unsigned CTL_ONESHOT_BIT = 3;
  localparam int unsigned CTL_FORCE_BIT   = 4;
  localparam logic [7:0]  CTL_START       = 8'h01;
  localparam logic [7:0]  CTL_FORCE       = 8'h10;
  localparam logic [7:0]  MODE_A_MASK     = 8'h21;
  localparam logic [7:0]  MODE_B_MASK     = 8'h61;
  localparam logic [7:0]  MODE_B_CASC     = 8'h41;
  localparam logic [7:0]  MODE_B_CASC_CNT = 8'h61;

  // Interrupt register fields
  localparam int unsigned INT_REQ_BIT  = 7;
  localparam int unsigned INT_SET_BIT  = 7;
  localparam logic [4:0]  INT_SRC_MASK = 5'h1f;

  localparam logic [15:0] TIMER_RESET = 16'hffff;

  // Commands into one timer
  typedef struct packed {
    logic       step;
    logic       wr_lo;
    logic       wr_hi;
    logic       wr_ctl;
    logic [7:0] data;
  } tmr_cmd_t;

  // Timer status
  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  ctl;
    logic        under;
  } tmr_stat_t;

  // Commands into the interrupt logic
  typedef struct packed {
    logic       ta_under;
    logic       tb_under;
    logic       rd_clr;
    logic       wr_mask;
    logic [7:0] data;
  } irq_cmd_t;

endpackage

`default_nettype wire

FILE: design/dual_interval_timer_with_interrupts.sv
`timescale 1ns / 1ps
`default_nettype none
// Two 16-bit interval timers with interrupt logic behind a byte register bus.
// Input channel: in_valid/in_stall carry one request each: a clock tick
// (opcode 0), a register read (1) or a register write (2) with
// in_reg_address and in_write_data. Opcode 3 is a no-op.
// Result channel: out_valid/out_stall return one result per request:
// out_read_data (read byte, zero otherwise) and out_irq_line, the
// interrupt request level after the request.
// Flow: a request is registered at acceptance in the input register, then,
// once the result register is free, executed against the timer state and its
// result registered in the result register, which drives the out_ ports.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; beyond that in_stall rises.
// Reset (synchronous, rst_n low) sets counts and latches to 0xffff, clears
// controls, mask, flags and plain storage, and empties both registers.

`include "dual_interval_timer_with_interrupts_assert.svh"

module dual_interval_timer_with_interrupts (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic [3:0] in_reg_address,
  input  wire logic [7:0] in_write_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic            out_irq_line
);

  // Input register
  logic       s1_valid_r;
  logic [1:0] s1_op_r;
  logic [3:0] s1_addr_r;
  logic [7:0] s1_data_r;

  // Result register
  logic       out_valid_r;
  logic [7:0] out_read_data_r;
  logic       out_irq_line_r;

  logic [7:0] plain_r [16];

  logic adv;
  logic in_take;
  logic is_tick, is_read, is_write;

  dit_pkg::tmr_cmd_t  cmd_a, cmd_b;
  dit_pkg::tmr_stat_t stat_a, stat_b;
  dit_pkg::irq_cmd_t  cmd_irq;
  logic [7:0]         icr_data;
  logic               irq_nxt;
  logic [7:0]         mode_b;
  logic [7:0]         rd_byte;

  // Handshake
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_opcode;
      s1_addr_r <= in_reg_address;
      s1_data_r <= in_write_data;
    end
  end

  // Request decode
  assign is_tick  = adv && (s1_op_r == dit_pkg::OP_TICK);
  assign is_read  = adv && (s1_op_r == dit_pkg::OP_READ);
  assign is_write = adv && (s1_op_r == dit_pkg::OP_WRITE);

  // Timer A counts ticks unless in pin-edge mode
  always_comb begin
    cmd_a.step   = is_tick && ((stat_a.ctl & dit_pkg::MODE_A_MASK) == dit_pkg::CTL_START);
    cmd_a.wr_lo  = is_write && (s1_addr_r == dit_pkg::ADDR_TA_LO);
    cmd_a.wr_hi  = is_write && (s1_addr_r == dit_pkg::ADDR_TA_HI);
    cmd_a.wr_ctl = is_write && (s1_addr_r == dit_pkg::ADDR_CRA);
    cmd_a.data   = s1_data_r;
  end

  // Timer B counts ticks or timer A underflows of the same tick
  assign mode_b = stat_b.ctl & dit_pkg::MODE_B_MASK;

  always_comb begin
    cmd_b.step   = is_tick && ((mode_b == dit_pkg::CTL_START) ||
                   (((mode_b == dit_pkg::MODE_B_CASC) ||
                     (mode_b == dit_pkg::MODE_B_CASC_CNT)) && stat_a.under));
    cmd_b.wr_lo  = is_write && (s1_addr_r == dit_pkg::ADDR_TB_LO);
    cmd_b.wr_hi  = is_write && (s1_addr_r == dit_pkg::ADDR_TB_HI);
    cmd_b.wr_ctl = is_write && (s1_addr_r == dit_pkg::ADDR_CRB);
    cmd_b.data   = s1_data_r;
  end

  dit_timer u_timer_a (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd_a),
    .stat (stat_a)
  );

  dit_timer u_timer_b (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd_b),
    .stat (stat_b)
  );

  // Interrupt flags and mask
  always_comb begin
    cmd_irq.ta_under = stat_a.under;
    cmd_irq.tb_under = stat_b.under;
    cmd_irq.rd_clr   = is_read && (s1_addr_r == dit_pkg::ADDR_ICR);
    cmd_irq.wr_mask  = is_write && (s1_addr_r == dit_pkg::ADDR_ICR);
    cmd_irq.data     = s1_data_r;
  end

  dit_irq u_irq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd_irq),
    .icr_data(icr_data),
    .irq_nxt (irq_nxt)
  );

  // Plain storage takes every written byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        plain_r[i] <= 8'h00;
      end
    end else if (is_write) begin
      plain_r[s1_addr_r] <= s1_data_r;
    end
  end

  // Read mux
  always_comb begin
    case (s1_addr_r)
      dit_pkg::ADDR_TA_LO: rd_byte = stat_a.count[7:0];
      dit_pkg::ADDR_TA_HI: rd_byte = stat_a.count[15:8];
      dit_pkg::ADDR_TB_LO: rd_byte = stat_b.count[7:0];
      dit_pkg::ADDR_TB_HI: rd_byte = stat_b.count[15:8];
      dit_pkg::ADDR_ICR:   rd_byte = icr_data;
      dit_pkg::ADDR_CRA:   rd_byte = stat_a.ctl;
      dit_pkg::ADDR_CRB:   rd_byte = stat_b.ctl;
      default:             rd_byte = plain_r[s1_addr_r];
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_read_data_r <= is_read ? rd_byte : 8'h00;
      out_irq_line_r  <= irq_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq_line  = out_irq_line_r;

  // Checks
  `DIT_ASSERT(a_stall_holds_s1, (s1_valid_r && !adv) |=> s1_valid_r)
  `DIT_ASSERT(a_nonread_zero, (adv && (s1_op_r != dit_pkg::OP_READ)) |=> (out_read_data == 8'h00))
  `DIT_ASSERT(a_icr_read_clears, cmd_irq.rd_clr |=> !out_irq_line)
  `DIT_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> s1_valid_r)

endmodule

`default_nettype wire

FILE: design/dit_timer.sv
`timescale 1ns / 1ps
`default_nettype none

module dit_timer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dit_pkg::tmr_cmd_t cmd,
  output dit_pkg::tmr_stat_t     stat
);

  logic [15:0] count_r, count_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic [7:0]  ctl_r, ctl_nxt;
  logic        under;

  // Count, reload latch and control update; one request can change more than one of them
  always_comb begin
    count_nxt = count_r;
    latch_nxt = latch_r;
    ctl_nxt   = ctl_r;
    under     = 1'b0;
    if (cmd.step) begin
      if (count_r != 16'd0) begin
        count_nxt = count_r - 16'd1;
      end else begin
        under     = 1'b1;
        count_nxt = latch_r;
        if (ctl_r[dit_pkg::CTL_ONESHOT_BIT]) begin
          ctl_nxt[dit_pkg::CTL_START_BIT] = 1'b0;
        end
      end
    end
    if (cmd.wr_lo) begin
      latch_nxt[7:0] = cmd.data;
    end
    if (cmd.wr_hi) begin
      latch_nxt[15:8] = cmd.data;
      // stopped timer loads the new period at once
      if (!ctl_r[dit_pkg::CTL_START_BIT]) begin
        count_nxt = {cmd.data, latch_r[7:0]};
      end
    end
    if (cmd.wr_ctl) begin
      ctl_nxt = cmd.data & ~dit_pkg::CTL_FORCE;
      if (cmd.data[dit_pkg::CTL_FORCE_BIT]) begin
        count_nxt = latch_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= dit_pkg::TIMER_RESET;
      latch_r <= dit_pkg::TIMER_RESET;
      ctl_r   <= 8'h00;
    end else begin
      count_r <= count_nxt;
      latch_r <= latch_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  assign stat.count = count_r;
  assign stat.ctl   = ctl_r;
  assign stat.under = under;

endmodule

`default_nettype wire

FILE: design/dit_irq.sv
`timescale 1ns / 1ps
`default_nettype none

module dit_irq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dit_pkg::irq_cmd_t cmd,
  output logic [7:0]             icr_data,
  output logic                   irq_nxt
);

  logic [4:0] mask_r, mask_nxt;
  logic [7:0] data_r, data_nxt;
  logic       check;

  // Latch sources, update mask, raise request when a set source is enabled
  always_comb begin
    mask_nxt = mask_r;
    data_nxt = data_r | {6'b0, cmd.tb_under, cmd.ta_under};
    check    = cmd.ta_under | cmd.tb_under;
    if (cmd.wr_mask) begin
      if (cmd.data[dit_pkg::INT_SET_BIT]) begin
        mask_nxt = mask_r | cmd.data[4:0];
      end else begin
        mask_nxt = mask_r & ~cmd.data[4:0];
      end
      check = (data_r != 8'h00);
    end
    if (check && ((mask_nxt & data_nxt[4:0] & dit_pkg::INT_SRC_MASK) != 5'd0)) begin
      data_nxt[dit_pkg::INT_REQ_BIT] = 1'b1;
    end
    // reading the register clears every flag
    if (cmd.rd_clr) begin
      data_nxt = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 5'd0;
      data_r <= 8'h00;
    end else begin
      mask_r <= mask_nxt;
      data_r <= data_nxt;
    end
  end

  assign icr_data = data_r;
  assign irq_nxt  = data_nxt[dit_pkg::INT_REQ_BIT];

endmodule

`default_nettype wire

FILE: tb/sv/dit_reply_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the timer block. It keeps its own copy of the timer
// state, predicts the reply to each accepted request, and compares the replies
// in order.
module dit_reply_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_reg_address,
  input  logic [7:0] in_write_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_read_data,
  input  logic       out_irq_line,
  output int         mismatch_count,
  output int         replies_due
);

  // Interrupt source flags
  localparam logic [7:0] INT_TA_FLAG = 8'h01;
  localparam logic [7:0] INT_TB_FLAG = 8'h02;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
  } reply_t;

  // Shadow timer state
  logic [15:0] cnt_a, cnt_b, latch_a, latch_b;
  logic [7:0]  ctrl_a, ctrl_b, int_flags;
  logic [4:0]  int_enable;
  logic [7:0]  plain_regs [16];

  reply_t reply_q [$];
  reply_t want, got;
  int     errs = 0;

  // Latch source flags; the request bit rises if any enabled source is set
  task automatic flag_irq(input logic [7:0] bits);
    int_flags = int_flags | bits;
    if ((int_enable & int_flags[4:0]) != 5'd0) int_flags[dit_pkg::INT_REQ_BIT] = 1'b1;
  endtask

  // One decrement of a running timer; zero reloads and raises its flag
  task automatic count_down(inout logic [15:0] cnt, input logic [15:0] latch,
                            inout logic [7:0] ctrl, input logic [7:0] flag,
                            output logic under);
    under = 1'b0;
    if (cnt != 16'd0) begin
      cnt = cnt - 16'd1;
    end else begin
      cnt = latch;
      if (ctrl[dit_pkg::CTL_ONESHOT_BIT]) ctrl[dit_pkg::CTL_START_BIT] = 1'b0;
      flag_irq(flag);
      under = 1'b1;
    end
  endtask

  // Timer A first, then timer B on ticks or on A underflows (cascade)
  task automatic clock_tick();
    logic       a_under, b_under;
    logic [7:0] mode_b;
    a_under = 1'b0;
    b_under = 1'b0;
    if ((ctrl_a & dit_pkg::MODE_A_MASK) == dit_pkg::CTL_START)
      count_down(cnt_a, latch_a, ctrl_a, INT_TA_FLAG, a_under);
    mode_b = ctrl_b & dit_pkg::MODE_B_MASK;
    if (mode_b == dit_pkg::CTL_START ||
        ((mode_b == dit_pkg::MODE_B_CASC || mode_b == dit_pkg::MODE_B_CASC_CNT) && a_under))
      count_down(cnt_b, latch_b, ctrl_b, INT_TB_FLAG, b_under);
  endtask

  task automatic bus_read(input logic [3:0] addr, output logic [7:0] data);
    case (addr)
      dit_pkg::ADDR_TA_LO: data = cnt_a[7:0];
      dit_pkg::ADDR_TA_HI: data = cnt_a[15:8];
      dit_pkg::ADDR_TB_LO: data = cnt_b[7:0];
      dit_pkg::ADDR_TB_HI: data = cnt_b[15:8];
      // read-to-clear
      dit_pkg::ADDR_ICR: begin
        data = int_flags;
        int_flags = 8'h00;
      end
      dit_pkg::ADDR_CRA: data = ctrl_a;
      dit_pkg::ADDR_CRB: data = ctrl_b;
      default:           data = plain_regs[addr];
    endcase
  endtask

  task automatic bus_write(input logic [3:0] addr, input logic [7:0] data);
    plain_regs[addr] = data;
    case (addr)
      dit_pkg::ADDR_TA_LO: latch_a[7:0] = data;
      dit_pkg::ADDR_TA_HI: begin
        latch_a[15:8] = data;
        if (!ctrl_a[dit_pkg::CTL_START_BIT]) cnt_a = latch_a;
      end
      dit_pkg::ADDR_TB_LO: latch_b[7:0] = data;
      dit_pkg::ADDR_TB_HI: begin
        latch_b[15:8] = data;
        if (!ctrl_b[dit_pkg::CTL_START_BIT]) cnt_b = latch_b;
      end
      // bit 7 picks set or clear of the enable bits
      dit_pkg::ADDR_ICR: begin
        if (data[dit_pkg::INT_SET_BIT])
          int_enable = int_enable | (data[4:0] & dit_pkg::INT_SRC_MASK);
        else
          int_enable = int_enable & ~data[4:0];
        if (int_flags != 8'h00) flag_irq(8'h00);
      end
      dit_pkg::ADDR_CRA: begin
        ctrl_a = data & ~dit_pkg::CTL_FORCE;
        if (data[dit_pkg::CTL_FORCE_BIT]) cnt_a = latch_a;
      end
      dit_pkg::ADDR_CRB: begin
        ctrl_b = data & ~dit_pkg::CTL_FORCE;
        if (data[dit_pkg::CTL_FORCE_BIT]) cnt_b = latch_b;
      end
      default: ;
    endcase
  endtask

  task automatic predict_reply(input logic [1:0] op, input logic [3:0] addr,
                               input logic [7:0] data, output reply_t r);
    logic [7:0] rd;
    rd = 8'h00;
    case (dit_pkg::op_t'(op))
      dit_pkg::OP_TICK:  clock_tick();
      dit_pkg::OP_READ:  bus_read(addr, rd);
      dit_pkg::OP_WRITE: bus_write(addr, data);
      default:  ;
    endcase
    r.read_data = rd;
    r.irq_line  = int_flags[dit_pkg::INT_REQ_BIT];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cnt_a      = dit_pkg::TIMER_RESET;
      cnt_b      = dit_pkg::TIMER_RESET;
      latch_a    = dit_pkg::TIMER_RESET;
      latch_b    = dit_pkg::TIMER_RESET;
      ctrl_a     = 8'h00;
      ctrl_b     = 8'h00;
      int_enable = 5'h00;
      int_flags  = 8'h00;
      for (int i = 0; i < 16; i++) plain_regs[i] = 8'h00;
      reply_q.delete();
    end else begin
      // accepted request: predict its reply
      if (in_valid && !in_stall) begin
        predict_reply(in_opcode, in_reg_address, in_write_data, want);
        reply_q.push_back(want);
      end
      // accepted reply: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        got.read_data = out_read_data;
        got.irq_line  = out_irq_line;
        if (reply_q.size() == 0) begin
          $display("%0t: reply with none pending: read_data %02h irq_line %b",
                   $time, got.read_data, got.irq_line);
          errs++;
        end else begin
          want = reply_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %02h actual %02h",
                     $time, want.read_data, got.read_data);
            errs++;
          end
          if (got.irq_line !== want.irq_line) begin
            $display("%0t: irq_line expected %b actual %b",
                     $time, want.irq_line, got.irq_line);
            errs++;
          end
        end
      end
    end
    mismatch_count <= errs;
    replies_due    <= reply_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_TAIL   = 100;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_opcode = 2'd0;
  logic [3:0] in_reg_address = 4'd0;
  logic [7:0] in_write_data = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq_line;

  int          mismatch_count;
  int          replies_due;
  bit          idle_on = 1'b1;
  int unsigned cycles = 0;

  dual_interval_timer_with_interrupts i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_reg_address (in_reg_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_irq_line   (out_irq_line)
  );

  dit_reply_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_reg_address (in_reg_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_irq_line   (out_irq_line),
    .mismatch_count (mismatch_count),
    .replies_due    (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[dual_interval_timer_with_interrupts] ERROR");
      $finish;
    end
  end

  // Receiver stalls in bursts while idling is on
  always @(posedge clk) begin
    if (rst_n && idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Present one request, hold it until taken, then maybe leave a gap
  task automatic issue(input logic [1:0] op, input logic [3:0] addr,
                       input logic [7:0] data);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_reg_address <= addr;
    in_write_data  <= data;
    do @(posedge clk); while (in_stall);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Mostly ticks with timer setups that keep periods short
  task automatic random_request();
    int         pick;
    logic [1:0] op;
    logic [3:0] addr;
    logic [7:0] data;
    pick = int'($urandom_range(0, 99));
    addr = 4'($urandom_range(0, 15));
    data = 8'($urandom_range(0, 255));
    if (pick < 55) begin
      op = dit_pkg::OP_TICK;
    end else if (pick < 72) begin
      op = dit_pkg::OP_READ;
      if ($urandom_range(0, 2) != 0)
        addr = ($urandom_range(0, 1) == 0) ? dit_pkg::ADDR_ICR : 4'($urandom_range(4, 7));
    end else if (pick < 96) begin
      op = dit_pkg::OP_WRITE;
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 6))
          0: addr = dit_pkg::ADDR_TA_LO;
          1: addr = dit_pkg::ADDR_TA_HI;
          2: addr = dit_pkg::ADDR_TB_LO;
          3: addr = dit_pkg::ADDR_TB_HI;
          4: addr = dit_pkg::ADDR_ICR;
          5: addr = dit_pkg::ADDR_CRA;
          default: addr = dit_pkg::ADDR_CRB;
        endcase
      end
      case (addr)
        dit_pkg::ADDR_TA_HI, dit_pkg::ADDR_TB_HI:
          if ($urandom_range(0, 9) != 0) data = 8'h00;
        dit_pkg::ADDR_TA_LO, dit_pkg::ADDR_TB_LO:
          if ($urandom_range(0, 4) != 0) data = 8'($urandom_range(0, 20));
        dit_pkg::ADDR_CRA: begin
          if ($urandom_range(0, 3) != 0) data = data | dit_pkg::CTL_START;
          if ($urandom_range(0, 4) != 0) data = data & ~8'h20;
        end
        dit_pkg::ADDR_CRB: if ($urandom_range(0, 3) != 0) data = data | dit_pkg::CTL_START;
        default: ;
      endcase
    end else begin
      op = OP_NOP;
    end
    issue(op, addr, data);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // one-shot timer A with forced load, irq, control read-back
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_TA_LO, 8'h02);
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_TA_HI, 8'h00);
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_ICR, 8'h83);
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_CRA, 8'h19);
    repeat (3) issue(dit_pkg::OP_TICK, 4'h0, 8'h00);
    issue(dit_pkg::OP_READ, dit_pkg::ADDR_CRA, 8'h00);
    // clearing the enable keeps the request up
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_ICR, 8'h01);
    issue(dit_pkg::OP_READ, dit_pkg::ADDR_ICR, 8'h00);
    // timer B cascaded from continuous timer A
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_TB_LO, 8'h01);
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_TB_HI, 8'h00);
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_CRB, 8'h51);
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_CRA, 8'h11);
    repeat (6) issue(dit_pkg::OP_TICK, 4'h0, 8'h00);
    // gated cascade, then pin-edge hold on A
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_CRB, 8'h71);
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_CRA, 8'h21);
    issue(dit_pkg::OP_TICK, 4'h0, 8'h00);
    // high latch write while running does not load
    issue(dit_pkg::OP_WRITE, dit_pkg::ADDR_TA_HI, 8'hff);
    issue(dit_pkg::OP_READ, dit_pkg::ADDR_TA_HI, 8'h00);
    // plain storage, unused opcode, interrupt register
    issue(dit_pkg::OP_WRITE, 4'h0, 8'hff);
    issue(dit_pkg::OP_READ, 4'h0, 8'h00);
    issue(OP_NOP, 4'hf, 8'hff);
    issue(dit_pkg::OP_READ, dit_pkg::ADDR_ICR, 8'h00);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0)
        idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      random_request();
    end
    in_valid <= 1'b0;

    // drain, then allow for pipeline latency
    do @(posedge clk); while (replies_due != 0);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[dual_interval_timer_with_interrupts] OK");
    end else begin
      $display("[dual_interval_timer_with_interrupts] ERROR");
    end
    $finish;
  end

endmodule
